/* src/dssf_pkg.sv */
// Shared types and constants for the decimal seven-segment frame unit.
package dssf_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_ADDR,
        S_SEG,
        S_DOT
    } state_t;

    localparam logic [7:0] ADDR_BYTE  = 8'hC0;
    localparam logic [7:0] DOT_BYTE   = 8'h00;
    localparam logic [7:0] BLANK_BYTE = 8'h00;

    // q = (v * RECIP_MULT) >> RECIP_SHIFT equals v / 10 for every 16-bit v
    localparam logic [16:0] RECIP_MULT  = 17'd52429;
    localparam int          RECIP_SHIFT = 19;

    // segment pattern, bit 0 = segment a .. bit 6 = segment g
    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0:    pat = 8'h3F;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h6F;
            default: pat = BLANK_BYTE;
        endcase
        return pat;
    endfunction

endpackage

/* src/decimal_seven_segment_frame_unit.sv */
// Decimal seven-segment frame unit: 16-bit value to one display write frame.
//
// Each accepted item (a 16-bit unsigned value) yields one frame of 1 + 2*DIGIT_POSITIONS
// bytes (17 at the default of 8): the address byte 0xC0, then for each position from left
// to right a segment byte and a dot byte of 0x00. Digits are right-aligned, leading
// positions are blank, and a value of zero shows all blanks. The final byte carries last;
// the consumer shifts each byte out LSB first and raises its strobe after it. The value is
// split into decimal digits by one shared divide-by-ten unit (a 16x17 reciprocal multiply
// plus a shift-and-subtract remainder), one digit per cycle, least significant first. Bytes
// then leave one per cycle, unless the consumer stalls, through a single output register.
// in_stall stays high from acceptance until the last byte has been loaded into the output
// register, so one value is worked on at a time.
module decimal_seven_segment_frame_unit #(
    parameter int DIGIT_POSITIONS = 8
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] value,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        last
);

    localparam int IDX_W  = $clog2(DIGIT_POSITIONS);
    localparam int NDIG_W = $clog2(DIGIT_POSITIONS + 1);

    dssf_pkg::state_t state_reg, state_next;

    // remaining quotient and digit store (least significant digit at index 0)
    logic [15:0]       work_reg, work_next;
    logic [3:0]        dig_reg [DIGIT_POSITIONS];
    logic [NDIG_W-1:0] ndig_reg, ndig_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;   // digit index counted from the right

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        frame_byte_reg, frame_byte_next;
    logic              last_reg, last_next;

    // divide-by-ten unit
    logic [32:0] prod;
    logic [15:0] quot;
    logic [15:0] quot_x10;
    logic [3:0]  rem;
    logic        dig_we;

    logic        in_accept;
    logic        out_free;   // output register can take a byte this cycle
    logic        out_load;
    logic [7:0]  seg_byte;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign prod     = 33'(work_reg) * 33'(dssf_pkg::RECIP_MULT);
    assign quot     = 16'(prod >> dssf_pkg::RECIP_SHIFT);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem      = 4'(work_reg - quot_x10);

    assign seg_byte = (NDIG_W'(pos_reg) < ndig_reg) ? dssf_pkg::seg_pattern(dig_reg[pos_reg])
                                                    : dssf_pkg::BLANK_BYTE;

    always_comb
    begin
        state_next      = state_reg;
        work_next       = work_reg;
        ndig_next       = ndig_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg;
        frame_byte_next = frame_byte_reg;
        last_next       = last_reg;
        dig_we          = 1'b0;
        out_load        = 1'b0;
        in_stall        = 1'b1;

        if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            dssf_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid) begin
                    work_next  = value;
                    ndig_next  = '0;
                    state_next = dssf_pkg::S_CONV;
                end
            end
            dssf_pkg::S_CONV:
            begin
                if (work_reg == 16'd0 || ndig_reg == NDIG_W'(DIGIT_POSITIONS)) begin
                    state_next = dssf_pkg::S_ADDR;
                end else begin
                    dig_we    = 1'b1;
                    work_next = quot;
                    ndig_next = ndig_reg + 1'b1;
                end
            end
            dssf_pkg::S_ADDR:
            begin
                if (out_free) begin
                    out_load        = 1'b1;
                    frame_byte_next = dssf_pkg::ADDR_BYTE;
                    last_next       = 1'b0;
                    pos_next        = IDX_W'(DIGIT_POSITIONS - 1);
                    state_next      = dssf_pkg::S_SEG;
                end
            end
            dssf_pkg::S_SEG:
            begin
                if (out_free) begin
                    out_load        = 1'b1;
                    frame_byte_next = seg_byte;
                    last_next       = 1'b0;
                    state_next      = dssf_pkg::S_DOT;
                end
            end
            dssf_pkg::S_DOT:
            begin
                if (out_free) begin
                    out_load        = 1'b1;
                    frame_byte_next = dssf_pkg::DOT_BYTE;
                    last_next       = (pos_reg == '0);
                    if (pos_reg == '0) begin
                        state_next = dssf_pkg::S_IDLE;
                    end else begin
                        pos_next   = pos_reg - 1'b1;
                        state_next = dssf_pkg::S_SEG;
                    end
                end
            end
            default:
            begin
                state_next = dssf_pkg::S_IDLE;
            end
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= dssf_pkg::S_IDLE;
            ndig_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ndig_reg      <= ndig_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        work_reg       <= work_next;
        frame_byte_reg <= frame_byte_next;
        last_reg       <= last_next;
        if (dig_we) begin
            dig_reg[ndig_reg[IDX_W-1:0]] <= rem;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign last       = last_reg;

    // an accepted value always starts a conversion
    a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == dssf_pkg::S_CONV)
        else $error("accepted value did not start conversion");

    // digit count stays within the display
    a_ndig_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ndig_reg <= NDIG_W'(DIGIT_POSITIONS))
        else $error("digit count overflow");

    // a byte loaded in the dot phase is a valid zero byte
    a_dot_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dssf_pkg::S_DOT && out_load)
            |=> (out_valid_reg && frame_byte_reg == dssf_pkg::DOT_BYTE))
        else $error("dot byte not zero");

    // stored digits are decimal
    a_digit_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        dig_we |-> rem <= 4'd9)
        else $error("remainder out of decimal range");

endmodule

/* verif/decimal_seven_segment_frame_unit_tb.sv */
// Testbench for the decimal seven-segment frame unit: frame prediction and byte-by-byte checks.
`timescale 1ns / 100ps

module decimal_seven_segment_frame_unit_tb;

    // Display width under test; one frame = address byte + (segment, dot) per position.
    localparam int DIGITS       = 8;
    localparam int FRAME_BYTES  = 1 + 2 * DIGITS;
    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 40;

    // Segment patterns for digits 0..9, bit 0 = segment a.
    localparam logic [7:0] SEG_CODES [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    // Receiver behavior, re-picked at random whenever the low seven bits of cyc are zero.
    typedef enum logic [1:0] {
        RX_READY,   // never stalls
        RX_LIGHT,   // stalls about a quarter of the time
        RX_HEAVY,   // stalls about half the time
        RX_RUNS     // stalls in runs, while cyc[3:0] is 12 or more
    } stall_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    // Holds the bytes still owed by the block, oldest first, and checks arrivals.
    class frame_check;
        frame_byte_t due_q [$];
        int unsigned bytes_checked;
        int unsigned mismatches;

        function int unsigned pending();
            return due_q.size();
        endfunction

        // Builds the full frame for one accepted value.
        function void note_value(logic [15:0] v);
            logic [3:0]  digit_at [DIGITS];   // index 0 = rightmost digit
            int unsigned rest;
            int          ndig;
            int          r;
            logic [7:0]  seg;
            rest = v;
            ndig = 0;
            while (rest != 0 && ndig < DIGITS) begin
                digit_at[ndig] = 4'(rest % 10);
                rest = rest / 10;
                ndig++;
            end
            due_q.push_back('{data: dssf_pkg::ADDR_BYTE, last: 1'b0});
            for (int p = 0; p < DIGITS; p++) begin
                r   = DIGITS - 1 - p;
                seg = (r < ndig) ? SEG_CODES[digit_at[r]] : dssf_pkg::BLANK_BYTE;
                due_q.push_back('{data: seg, last: 1'b0});
                due_q.push_back('{data: dssf_pkg::DOT_BYTE, last: (p == DIGITS - 1)});
            end
        endfunction

        function void check_byte(logic [7:0] got_byte, logic got_last);
            frame_byte_t due;
            if (due_q.size() == 0) begin
                $error("frame_byte: unexpected byte %02h (last %0b), no frame pending",
                       got_byte, got_last);
                mismatches++;
                return;
            end
            due = due_q.pop_front();
            bytes_checked++;
            if (got_byte !== due.data) begin
                $error("frame_byte mismatch: expected %02h, actual %02h", due.data, got_byte);
                mismatches++;
            end
            if (got_last !== due.last) begin
                $error("last mismatch: expected %0b, actual %0b", due.last, got_last);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [15:0] value     = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  frame_byte;
    logic        last;

    frame_check  frames = new();

    stall_mode_t stall_mode   = RX_READY;
    logic [15:0] cyc          = '0;
    int unsigned values_sent  = 0;
    int unsigned zero_values  = 0;
    int unsigned wide_values  = 0;   // five-digit values

    decimal_seven_segment_frame_unit #(
        .DIGIT_POSITIONS(DIGITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .frame_byte(frame_byte),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Both handshakes are sampled at the rising edge, before this edge's updates land.
    // The value is noted first so a frame is always predicted before its bytes can show.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                frames.note_value(value);
            if (out_valid && !out_stall)
                frames.check_byte(frame_byte, last);
        end
    end

    // Receiver: the stall pattern is re-picked at random whenever the low seven bits of cyc
    // are zero; RX_READY gives stretches with no back-pressure at all.
    always @(posedge clk)
    begin
        cyc <= cyc + 16'd1;
        if (cyc[6:0] == 7'd0)
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
        case (stall_mode)
            RX_READY: out_stall <= 1'b0;
            RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
            RX_RUNS:  out_stall <= (cyc[3:0] >= 4'd12);
            default:  out_stall <= 1'b0;
        endcase
    end

    // Present one item and hold it until accepted. Valid is left high on return, so
    // the next call or an idle stretch decides what happens to it, one assignment per edge.
    task automatic send_value(input logic [15:0] v);
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        values_sent++;
        if (v == 16'd0)
            zero_values++;
        if (v >= 16'd10000)
            wide_values++;
    endtask

    // Gap between bursts; the payload wanders while valid is low.
    task automatic idle_cycles(input int unsigned n);
        in_valid <= 1'b0;
        value    <= 16'($urandom);
        repeat (n) @(posedge clk);
    endtask

    // Hold the sender until every outstanding frame has come out.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (frames.pending() != 0);
    endtask

    // Spread values over every decimal length, with zero and raw 16-bit values mixed in.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'($urandom_range(1, 9));
            2:       return 16'($urandom_range(10, 99));
            3:       return 16'($urandom_range(100, 999));
            4:       return 16'($urandom_range(1000, 9999));
            5:       return 16'($urandom_range(10000, 65535));
            6:       return 16'($urandom_range(65500, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] directed [$];
        int unsigned burst;
        int unsigned random_sent;
        logic        drained_once;

        // Digit-count boundaries, all-blank zero, full-scale, every digit 0..9,
        // and alternating bit patterns so each value bit is seen at 0 and 1.
        directed = '{
            16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
            16'd9999, 16'd10000, 16'd65535, 16'd65534, 16'd32768, 16'd12345,
            16'd60789, 16'd50, 16'h5555, 16'hAAAA, 16'd0, 16'd7
        };
        random_sent  = 0;
        drained_once = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_value(directed[i]);
            if ($urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 30));
        end

        // Random part: bursts of back-to-back items, often with gaps of varied length between them.
        while (random_sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                send_value(pick_value());
                random_sent++;
            end
            if (!drained_once && random_sent >= RANDOM_ITEMS / 2)
            begin
                hold_until_drained();
                drained_once = 1'b1;
            end
            else if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 40));
        end

        hold_until_drained();
        // Catch any stray bytes beyond the last frame.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d values (%0d zero, %0d five-digit) and %0d frame bytes",
                 values_sent, zero_values, wide_values, frames.bytes_checked);
        $display("  under %0d-position frames of %0d bytes with mixed stall modes",
                 DIGITS, FRAME_BYTES);
        if (frames.mismatches == 0 && frames.pending() == 0)
            $display("decimal_seven_segment_frame_unit_tb: clean");
        else
            $display("decimal_seven_segment_frame_unit_tb: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (every byte under heavy stall).
    initial
    begin
        #5_000_000;
        $display("decimal_seven_segment_frame_unit_tb: errors");
        $finish;
    end

endmodule
